FILE: sv/pcg_pkg.sv
// Shared types, constants and the output permutation of the PCG32 random source.
`default_nettype none

package pcg_pkg;

    // Command codes carried in the low bits of the slave tdata.
    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_RANGE  = 2'd2;
    localparam logic [1:0] CMD_FRAC   = 2'd3;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    // LCG multiplier and the constants of the two-step jump used by the generator loop.
    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_MULT2 = LCG_MULT * LCG_MULT;

    // After a reseed every start value is seed * K + D with fixed K and D.
    localparam logic [63:0] K_INC = (LCG_MULT << 1) + 64'd2;
    localparam logic [63:0] D_INC = LCG_MULT + 64'd1;
    localparam logic [63:0] K_S0  = LCG_MULT + 64'd2;
    localparam logic [63:0] D_S0  = 64'd1;
    localparam logic [63:0] K_S1  = LCG_MULT2 + (LCG_MULT << 1) + 64'd2;
    localparam logic [63:0] D_S1  = LCG_MULT + 64'd1;

    // One classified command waiting for the back end.
    typedef struct packed {
        logic [1:0]  cmd;
        logic        draw;
        logic [31:0] range_min;
        logic [31:0] span;
    } pcg_cmd_t;

    // Requests from the back end to the word generator.
    typedef struct packed {
        logic restart;
        logic pop;
    } pcg_wq_ctl_t;

    // XSH-RR output function applied to the state before its update.
    function automatic logic [31:0] pcg_permute(input logic [63:0] old);
        logic [63:0] mixed;
        logic [31:0] x;
        logic [4:0]  rot;
        logic [63:0] doubled;
        mixed   = (old >> 18) ^ old;
        x       = mixed[58:27];
        rot     = old[63:59];
        doubled = {x, x} >> rot;
        return doubled[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/pcg_fifo.sv
// Small first-in first-out queue in flip-flops with a synchronous flush.
`default_nettype none

module pcg_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             flush,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  valid,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign valid    = (count_reg != '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full && !flush;
    assign do_pop   = pop && valid && !flush;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (flush)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_next = count_reg + 1'b1;
                2'b01:   count_next = count_reg - 1'b1;
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; only entries below the fill count are read.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pcg_front.sv
// Front end: accepts command beats, classifies them and queues them for the back end.
`default_nettype none

module pcg_front #(
    parameter int CMDQ_DEPTH = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pcg_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  cmd_valid,
    output pcg_pkg::pcg_cmd_t                     cmd_entry,
    input  wire logic                             cmd_pop
);

    import pcg_pkg::*;

    localparam int CMD_W = $bits(pcg_cmd_t);

    logic [1:0]       in_cmd;
    logic [31:0]      in_min;
    logic [31:0]      in_max;
    logic             in_empty;
    pcg_cmd_t         in_entry;
    logic             q_full;
    logic [CMD_W-1:0] q_data;

    assign in_cmd = s_tdata[1:0];
    assign in_min = s_tdata[33:2];
    assign in_max = s_tdata[65:34];

    // Classify: an empty or inverted range makes no draw; every other non-reseed beat does.
    always_comb
    begin
        in_empty           = ($signed(in_min) >= $signed(in_max));
        in_entry.cmd       = in_cmd;
        in_entry.range_min = in_min;
        in_entry.span      = in_max - in_min + 32'd1;
        unique case (in_cmd)
            CMD_RESEED: in_entry.draw = 1'b0;
            CMD_RAW:    in_entry.draw = 1'b1;
            CMD_RANGE:  in_entry.draw = !in_empty;
            CMD_FRAC:   in_entry.draw = 1'b1;
            default:    in_entry.draw = 1'b0;
        endcase
    end

    assign s_tready  = !q_full;
    assign cmd_entry = pcg_cmd_t'(q_data);

    pcg_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (1'b0),
        .push      (s_tvalid && s_tready),
        .push_data (in_entry),
        .pop       (cmd_pop),
        .pop_data  (q_data),
        .valid     (cmd_valid),
        .full      (q_full)
    );

endmodule

`default_nettype wire

FILE: sv/pcg_gen.sv
// Word generator: a two-stage multiply-add loop that runs the LCG ahead into a word queue.
`default_nettype none

module pcg_gen #(
    parameter int WQ_DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [63:0]          seed,
    input  wire pcg_pkg::pcg_wq_ctl_t ctl,
    output logic                      word_valid,
    output logic [31:0]               word
);

    import pcg_pkg::*;

    // Token kinds travelling through the multiply loop.
    localparam logic [1:0] TOK_NONE  = 2'd0;
    localparam logic [1:0] TOK_INC   = 2'd1;
    localparam logic [1:0] TOK_STATE = 2'd2;

    // Start-up sequence after a reseed.
    localparam logic [1:0] SETUP_IDLE = 2'd0;
    localparam logic [1:0] SETUP_INC  = 2'd1;
    localparam logic [1:0] SETUP_S0   = 2'd2;
    localparam logic [1:0] SETUP_S1   = 2'd3;

    logic [1:0]  setup_reg, setup_next;
    logic [63:0] seed_hold_reg, seed_hold_next;
    logic [63:0] c2_reg, c2_next;
    logic [1:0]  mul_kind_reg, mul_kind_next;
    logic [63:0] mul_ll_reg, mul_ll_next;
    logic [31:0] mul_x_reg, mul_x_next;
    logic [63:0] mul_add_reg, mul_add_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [63:0] res_state_reg, res_state_next;

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] op_add;
    logic [1:0]  op_kind;
    logic        wq_full;
    logic        adv;
    logic        push;

    // The loop holds while a finished state cannot enter the full word queue.
    assign adv  = !((res_kind_reg == TOK_STATE) && wq_full);
    assign push = adv && (res_kind_reg == TOK_STATE) && !ctl.restart;

    // Operand selection: start-up values from the seed, else a two-step jump.
    always_comb
    begin
        unique case (setup_reg)
            SETUP_INC:
            begin
                op_a    = seed_hold_reg;
                op_b    = K_INC;
                op_add  = D_INC;
                op_kind = TOK_INC;
            end
            SETUP_S0:
            begin
                op_a    = seed_hold_reg;
                op_b    = K_S0;
                op_add  = D_S0;
                op_kind = TOK_STATE;
            end
            SETUP_S1:
            begin
                op_a    = seed_hold_reg;
                op_b    = K_S1;
                op_add  = D_S1;
                op_kind = TOK_STATE;
            end
            default:
            begin
                op_a    = res_state_reg;
                op_b    = LCG_MULT2;
                op_add  = c2_reg;
                op_kind = (res_kind_reg == TOK_STATE) ? TOK_STATE : TOK_NONE;
            end
        endcase
    end

    // Next-state logic of the loop: partial products, then the low 64 bits of the sum.
    always_comb
    begin
        setup_next     = setup_reg;
        seed_hold_next = seed_hold_reg;
        c2_next        = c2_reg;
        mul_kind_next  = mul_kind_reg;
        mul_ll_next    = mul_ll_reg;
        mul_x_next     = mul_x_reg;
        mul_add_next   = mul_add_reg;
        res_kind_next  = res_kind_reg;
        res_state_next = res_state_reg;
        if (ctl.restart)
        begin
            setup_next     = SETUP_INC;
            seed_hold_next = seed;
            mul_kind_next  = TOK_NONE;
            res_kind_next  = TOK_NONE;
        end
        else if (adv)
        begin
            unique case (setup_reg)
                SETUP_INC: setup_next = SETUP_S0;
                SETUP_S0:  setup_next = SETUP_S1;
                SETUP_S1:  setup_next = SETUP_IDLE;
                default:   setup_next = SETUP_IDLE;
            endcase
            if (res_kind_reg == TOK_INC)
            begin
                c2_next = res_state_reg;
            end
            mul_kind_next  = op_kind;
            mul_ll_next    = {32'd0, op_a[31:0]} * {32'd0, op_b[31:0]};
            mul_x_next     = op_a[31:0] * op_b[63:32] + op_a[63:32] * op_b[31:0];
            mul_add_next   = op_add;
            res_kind_next  = mul_kind_reg;
            res_state_next = mul_ll_reg + {mul_x_reg, 32'd0} + mul_add_reg;
        end
    end

    // Reset leaves state 0 at the head and state 1 in flight, with increment 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg     <= SETUP_IDLE;
            seed_hold_reg <= '0;
            c2_reg        <= LCG_MULT + 64'd1;
            mul_kind_reg  <= TOK_STATE;
            mul_ll_reg    <= '0;
            mul_x_reg     <= '0;
            mul_add_reg   <= 64'd1;
            res_kind_reg  <= TOK_STATE;
            res_state_reg <= '0;
        end
        else
        begin
            setup_reg     <= setup_next;
            seed_hold_reg <= seed_hold_next;
            c2_reg        <= c2_next;
            mul_kind_reg  <= mul_kind_next;
            mul_ll_reg    <= mul_ll_next;
            mul_x_reg     <= mul_x_next;
            mul_add_reg   <= mul_add_next;
            res_kind_reg  <= res_kind_next;
            res_state_reg <= res_state_next;
        end
    end

    // Permuted words waiting for draws, flushed on a reseed.
    pcg_fifo #(
        .WIDTH (32),
        .DEPTH (WQ_DEPTH)
    ) u_word_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (ctl.restart),
        .push      (push),
        .push_data (pcg_permute(res_state_reg)),
        .pop       (ctl.pop),
        .pop_data  (word),
        .valid     (word_valid),
        .full      (wq_full)
    );

endmodule

`default_nettype wire

FILE: sv/pcg_back.sv
// Back end: pairs commands with words, scales ranged draws and holds the result beat.
`default_nettype none

module pcg_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire pcg_pkg::pcg_cmd_t             cmd_entry,
    output logic                               cmd_pop,
    input  wire logic                          word_valid,
    input  wire logic [31:0]                   word,
    output pcg_pkg::pcg_wq_ctl_t               wq_ctl,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pcg_pkg::M_TDATA_W-1:0]      m_tdata
);

    import pcg_pkg::*;

    logic        p_valid_reg, p_valid_next;
    logic [1:0]  p_cmd_reg;
    logic [31:0] p_umin_reg;
    logic [31:0] p_word_reg;
    logic [63:0] p_prod_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_raw_reg;
    logic [31:0] out_ranged_reg;
    logic [23:0] out_frac_reg;

    logic        out_free;
    logic        p_free;
    logic [31:0] word_used;
    logic [31:0] ranged;
    logic [23:0] frac;

    assign out_free = !out_valid_reg || m_tready;
    assign p_free   = !p_valid_reg || out_free;

    // Take a command once its word, if it needs one, is at hand.
    assign cmd_pop        = cmd_valid && (!cmd_entry.draw || word_valid) && p_free;
    assign wq_ctl.pop     = cmd_pop && cmd_entry.draw;
    assign wq_ctl.restart = cmd_pop && (cmd_entry.cmd == CMD_RESEED);
    assign word_used      = cmd_entry.draw ? word : 32'd0;

    // Result fields; a skipped draw leaves a zero word and a zero product.
    always_comb
    begin
        ranged = (p_cmd_reg == CMD_RANGE) ? p_umin_reg + p_prod_reg[63:32] : 32'd0;
        frac   = (p_cmd_reg == CMD_FRAC) ? p_word_reg[31:8] : 24'd0;
    end

    always_comb
    begin
        p_valid_next   = p_free ? cmd_pop : p_valid_reg;
        out_valid_next = out_free ? p_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Product stage: draw times span.
    always_ff @(posedge clk)
    begin
        if (p_free)
        begin
            p_cmd_reg  <= cmd_entry.cmd;
            p_umin_reg <= cmd_entry.range_min;
            p_word_reg <= word_used;
            p_prod_reg <= {32'd0, word_used} * {32'd0, cmd_entry.span};
        end
    end

    // Output register, held while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_raw_reg    <= p_word_reg;
            out_ranged_reg <= ranged;
            out_frac_reg   <= frac;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_frac_reg, out_ranged_reg, out_raw_reg};

endmodule

`default_nettype wire

FILE: sv/pcg32_random_with_range.sv
// PCG32 (XSH-RR) random source with raw, ranged-integer and fraction commands.
//
// Channels: each slave beat carries one command (reseed, raw word, ranged
// integer, fraction) and produces exactly one master beat with raw_word,
// ranged_value and fraction; fields a command does not produce are zero.
// The seed register is written through cfg_wr_en / cfg_wr_data and used by
// the next reseed command.
// Throughput: one beat per cycle while m_tready is high and a word is
// ready. The LCG runs ahead in a two-stage multiply-add loop holding two
// interleaved states, jumping two steps per pass, and fills a short word
// queue that draws take from. A command passes the command queue and
// the product and output registers. After a reseed the loop restarts
// from the new seed; the next draw waits for the first new word.
// Reset: state 0, increment 1, seed 0; no start-up pass is needed.
// Stalls: the output register holds its beat while m_tready is low; the
// command queue keeps taking beats until it is full, then s_tready drops.
`default_nettype none

module pcg32_random_with_range #(
    parameter int CMDQ_DEPTH = 4,
    parameter int WQ_DEPTH   = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [63:0]                   cfg_wr_data,    // seed_value
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cmd [1:0], range_min [33:2], range_max [65:34], zero pad [71:66]
    input  wire logic [pcg_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // raw_word [31:0], ranged_value [63:32], fraction [87:64]
    output logic [pcg_pkg::M_TDATA_W-1:0]      m_tdata
);

    import pcg_pkg::*;

    logic [63:0] seed_value_reg;
    logic        cmd_valid;
    pcg_cmd_t    cmd_entry;
    logic        cmd_pop;
    logic        word_valid;
    logic [31:0] word;
    pcg_wq_ctl_t wq_ctl;

    // Seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            seed_value_reg <= cfg_wr_data;
        end
    end

    pcg_front #(
        .CMDQ_DEPTH (CMDQ_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_entry (cmd_entry),
        .cmd_pop   (cmd_pop)
    );

    pcg_gen #(
        .WQ_DEPTH (WQ_DEPTH)
    ) u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_value_reg),
        .ctl        (wq_ctl),
        .word_valid (word_valid),
        .word       (word)
    );

    pcg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_entry  (cmd_entry),
        .cmd_pop    (cmd_pop),
        .word_valid (word_valid),
        .word       (word),
        .wq_ctl     (wq_ctl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // A draw only takes a word that is there.
    assert property (@(posedge clk) disable iff (!rst_n) wq_ctl.pop |-> word_valid)
        else $error("word taken from an empty word queue");

    // A reseed makes no draw of its own.
    assert property (@(posedge clk) disable iff (!rst_n) wq_ctl.restart |-> !wq_ctl.pop)
        else $error("reseed and draw in the same cycle");

    // A reseed discards every word of the old sequence.
    assert property (@(posedge clk) disable iff (!rst_n) wq_ctl.restart |=> !word_valid)
        else $error("stale word left after reseed");

endmodule

`default_nettype wire

FILE: verif/tb_pcg32_random_with_range.sv
// Self-checking testbench for the PCG32 random source with raw, ranged and fraction commands.
`default_nettype none

// Predicts the result beat of each accepted command and checks the beats that come back.
class pcg_draw_scoreboard;

    localparam logic [63:0] MULTIPLIER = 64'd6364136223846793005;

    typedef struct {
        logic [31:0] raw_word;
        logic [31:0] ranged_value;
        logic [23:0] fraction;
    } draw_result_t;

    logic [63:0]  seed;
    logic [63:0]  lcg_state;
    logic [63:0]  lcg_incr;
    draw_result_t expected_draws[$];
    int           failures;

    // State and register values right after reset.
    function void reset_state();
        seed      = '0;
        lcg_state = '0;
        lcg_incr  = 64'd1;
        failures  = 0;
        expected_draws.delete();
    endfunction

    function void load_seed(input logic [63:0] value);
        seed = value;
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction

    // One LCG step; the word is the XSH-RR permutation of the state before the step.
    function logic [31:0] next_word();
        logic [63:0] prev;
        logic [31:0] xs;
        logic [4:0]  rot;
        prev      = lcg_state;
        lcg_state = prev * MULTIPLIER + lcg_incr;
        xs        = 32'(((prev >> 18) ^ prev) >> 27);
        rot       = prev[63:59];
        if (rot == 0)
            return xs;
        return (xs >> rot) | (xs << (6'd32 - rot));
    endfunction

    // Works out the result of an accepted command and queues it.
    function void note_command(input logic [1:0] cmd, input logic [31:0] lo,
                               input logic [31:0] hi);
        draw_result_t res;
        logic [31:0]  span;
        logic [63:0]  product;
        res = '{32'd0, 32'd0, 24'd0};
        case (cmd)
            pcg_pkg::CMD_RESEED:
            begin
                lcg_incr  = {seed[62:0], 1'b1};
                lcg_state = seed * MULTIPLIER + lcg_incr;
            end
            pcg_pkg::CMD_RAW:
            begin
                res.raw_word = next_word();
            end
            pcg_pkg::CMD_RANGE:
            begin
                // An empty or inverted range returns the lower bound without a draw.
                if ($signed(lo) >= $signed(hi))
                begin
                    res.ranged_value = lo;
                end
                else
                begin
                    span             = hi - lo + 32'd1;
                    res.raw_word     = next_word();
                    product          = {32'd0, res.raw_word} * {32'd0, span};
                    res.ranged_value = lo + product[63:32];
                end
            end
            default:
            begin
                res.raw_word = next_word();
                res.fraction = res.raw_word[31:8];
            end
        endcase
        expected_draws.push_back(res);
    endfunction

    function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("MISMATCH %s: expected %08h, got %08h", what, want, got);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_beat(input logic [pcg_pkg::M_TDATA_W-1:0] beat);
        draw_result_t want;
        if (expected_draws.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("MISMATCH unexpected result beat %022h", beat);
            return;
        end
        want = expected_draws.pop_front();
        if (beat[31:0] !== want.raw_word)
            flag("raw_word", want.raw_word, beat[31:0]);
        if (beat[63:32] !== want.ranged_value)
            flag("ranged_value", want.ranged_value, beat[63:32]);
        if (beat[87:64] !== want.fraction)
            flag("fraction", {8'd0, want.fraction}, {8'd0, beat[87:64]});
    endfunction

endclass

module tb_pcg32_random_with_range;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 175;
    localparam int SQUEEZE_AFTER = 400;
    localparam int SQUEEZE_LEN   = 150;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [63:0]                   cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pcg_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pcg_pkg::M_TDATA_W-1:0] m_tdata;

    pcg_draw_scoreboard sb;
    int                 beats_sent = 0;
    int                 cycles = 0;
    int                 rx_cycles = 0;
    int                 rx_hold = 0;
    int                 rx_pick;
    bit                 squeeze_done = 1'b0;
    logic [63:0]        phase_seeds[6];

    pcg32_random_with_range u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: calm windows, short and long stalls, and one long hold-off to fill the block.
    always @(posedge clk)
    begin
        rx_cycles++;
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (!squeeze_done && beats_sent >= SQUEEZE_AFTER)
        begin
            squeeze_done = 1'b1;
            rx_hold      = SQUEEZE_LEN;
            m_tready     <= 1'b0;
        end
        else if (rx_cycles % 256 < 48)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70)
            begin
                m_tready <= 1'b1;
            end
            else if (rx_pick < 96)
            begin
                rx_hold  = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_hold  = $urandom_range(10, 40) - 1;
                m_tready <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
    end

    // Sender gap: none in calm stretches, else mostly none, sometimes short and a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (beats_sent % 128 < 32 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one command beat and waits until it is taken.
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] lo,
                            input logic [31:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, hi, lo, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(cmd, lo, hi);
        beats_sent++;
    endtask

    // Writes the seed once every pending result has come back.
    task automatic write_seed(input logic [63:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.load_seed(value);
        cfg_wr_en <= 1'b0;
    endtask

    // One random command; ranged commands mix wide, narrow, empty and extreme bounds.
    task automatic send_random();
        int          r;
        logic [1:0]  cmd;
        logic [31:0] lo;
        logic [31:0] hi;
        r  = $urandom_range(0, 99);
        lo = $urandom();
        hi = $urandom();
        if (r < 8)
            cmd = pcg_pkg::CMD_RESEED;
        else if (r < 38)
            cmd = pcg_pkg::CMD_RAW;
        else if (r < 78)
            cmd = pcg_pkg::CMD_RANGE;
        else
            cmd = pcg_pkg::CMD_FRAC;
        if (cmd == pcg_pkg::CMD_RANGE)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                hi = lo + $urandom_range(1, 20);
            else if (r < 45)
                hi = lo;
            else if (r < 52)
            begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            else if (r < 60)
                lo = 32'h8000_0000 + $urandom_range(0, 3);
        end
        send_cmd(cmd, lo, hi);
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        phase_seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_seeds[1] = 64'd0;
        phase_seeds[2] = {$urandom(), $urandom()};
        phase_seeds[3] = 64'd1;
        phase_seeds[4] = 64'h8000_0000_0000_0000;
        phase_seeds[5] = {$urandom(), $urandom()};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: draws from the zero state, range corner cases, reseed with the reset seed.
        send_cmd(pcg_pkg::CMD_RAW, 32'd0, 32'd0);
        send_cmd(pcg_pkg::CMD_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(pcg_pkg::CMD_FRAC, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(pcg_pkg::CMD_RANGE, 32'd5, 32'd5);
        send_cmd(pcg_pkg::CMD_RANGE, 32'd10, -32'sd10);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h8000_0000, 32'h8000_0001);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
        send_cmd(pcg_pkg::CMD_RANGE, 32'hFFFF_FFFF, 32'd0);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h8000_0000, 32'h7FFF_FFFE);
        send_cmd(pcg_pkg::CMD_RANGE, 32'd0, 32'h7FFF_FFFF);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h8000_0000, 32'h8000_0000);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(pcg_pkg::CMD_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(pcg_pkg::CMD_RAW, 32'd0, 32'd0);
        send_cmd(pcg_pkg::CMD_FRAC, 32'd0, 32'd0);
        send_cmd(pcg_pkg::CMD_RANGE, 32'd1, 32'd6);
        send_cmd(pcg_pkg::CMD_RANGE, -32'sd100, 32'd100);
        send_cmd(pcg_pkg::CMD_RESEED, 32'd0, 32'd0);
        send_cmd(pcg_pkg::CMD_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);

        // Random phases, each under its own seed.
        foreach (phase_seeds[p])
        begin
            write_seed(phase_seeds[p]);
            send_cmd(pcg_pkg::CMD_RESEED, $urandom(), $urandom());
            repeat (PHASE_ITEMS) send_random();
        end

        // Drain and settle.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/pcg_pkg.sv
sv/pcg_fifo.sv
sv/pcg_front.sv
sv/pcg_gen.sv
sv/pcg_back.sv
sv/pcg32_random_with_range.sv
verif/tb_pcg32_random_with_range.sv
